[hw/rtl/c8x_pkg.sv]
// ============================================================================
// c8x_pkg: shared types and constants for the CHIP-8 instruction executor
// Holds the command codes, status codes, sizes and the controller interface.
// ============================================================================
package c8x_pkg;

	localparam int MEM_BYTES   = 4096;
	localparam int MEM_AW      = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH = 16;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;
	localparam int ROW_AW      = $clog2(SCREEN_H);
	localparam int COL_AW      = $clog2(SCREEN_W);

	localparam logic [MEM_AW-1:0] START_RESET = MEM_AW'(512);

	// Command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EXEC  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_IGNORED   = 2'd3;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic mem_clr;       // write zero to the next memory byte after reset
		logic mem_rd_pc;     // read memory at pc (high byte)
		logic mem_rd_pc1;    // read memory at pc+1
		logic mem_rd_spr;    // read memory at I + row count
		logic mem_wr_cmd;    // write command byte to memory
		logic latch_hi;      // capture high byte of opcode
		logic latch_lo;      // capture low byte of opcode
		logic exec;          // execute a non-draw, non-clear opcode
		logic clr_start;     // start clearing the screen
		logic clr_step;      // clear one row
		logic spr_start;     // start sprite draw
		logic spr_step;      // xor one sprite row
		logic spr_end;       // write collision flag
		logic rd_row;        // latch display row into result
		logic res_clear;     // clear result fields for a new command
	} c8x_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mclr_last;
		logic is_cls;
		logic is_drw;
		logic clr_last;
		logic spr_last;
		logic spr_none;
	} c8x_sts_t;

endpackage

[hw/rtl/chip8_instruction_executor.sv]
// ============================================================================
// chip8_instruction_executor: CHIP-8 instruction executor top level
// Channel   | Direction | Content
// s_axis    | in        | tdata: command[1:0] address[13:2] data[21:14] row[26:22]
// m_axis    | out       | tdata: pc[11:0] word[27:12] status[29:28] flag[37:30] row[101:38]
// cfg       | in        | start_address[11:0], loaded into the program counter
// After accept, a write, row read or unused command goes straight to its result; an
// execute fetches and decodes the opcode, then a clear clears one row per cycle and a
// draw reads and xors each sprite row in turn, paced by the single memory port with
// registered read. After reset a clearing pass zeroes all 4096 memory bytes, one per
// cycle, and holds off the input until it ends. The result waits in an output register;
// the next command is worked on meanwhile and only its own result stalls.
// ============================================================================
module chip8_instruction_executor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // command, address, data, row
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // pc, word, status, flag, row bits
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [11:0]  cfg_data
);
	import c8x_pkg::*;

	c8x_cmd_t cmd;
	c8x_sts_t sts;
	logic in_fire, out_fire, in_rdy, res_load;
	logic [MEM_AW-1:0] pc_w;
	logic [15:0] word_w;
	logic [1:0]  st_w;
	logic [7:0]  flag_w;
	logic [63:0] row_w;
	logic        out_v_q;
	logic [103:0] out_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = in_rdy;
	assign in_fire       = s_axis_tvalid && in_rdy;
	assign out_fire      = out_v_q && m_axis_tready;

	c8x_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_cmd   (s_axis_tdata[1:0]),
		.out_busy (out_v_q),
		.out_fire (out_fire),
		.sts      (sts),
		.cmd      (cmd),
		.in_rdy   (in_rdy),
		.res_load (res_load)
	);

	c8x_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.in_fire    (in_fire),
		.in_address (s_axis_tdata[13:2]),
		.in_data    (s_axis_tdata[21:14]),
		.in_row     (s_axis_tdata[26:22]),
		.pc_out     (pc_w),
		.word_out   (word_w),
		.status_out (st_w),
		.flag_out   (flag_w),
		.row_out    (row_w)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_load) begin
			out_v_q <= 1'b1;
		end else if (out_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= {2'd0, row_w, flag_w, st_w, word_w, pc_w};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	logic unused_hi;
	assign unused_hi = ^s_axis_tdata[31:27];

endmodule

[hw/rtl/c8x_ram.sv]
// ============================================================================
// c8x_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ============================================================================
module c8x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[hw/rtl/c8x_ctrl.sv]
// ============================================================================
// c8x_ctrl: command sequencer
// Steps each accepted command through fetch, execute, clear or draw states.
// ============================================================================
module c8x_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [1:0]          in_cmd,
	input  logic                out_busy,
	input  logic                out_fire,
	input  c8x_pkg::c8x_sts_t   sts,
	output c8x_pkg::c8x_cmd_t   cmd,
	output logic                in_rdy,
	output logic                res_load
);
	import c8x_pkg::*;

	typedef enum logic [10:0] {
		S_MCLR  = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_FHI   = 11'b00000000100,
		S_FLO   = 11'b00000001000,
		S_GETLO = 11'b00000010000,
		S_DEC   = 11'b00000100000,
		S_CLR   = 11'b00001000000,
		S_SRD   = 11'b00010000000,
		S_SXOR  = 11'b00100000000,
		S_SEND  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign in_rdy = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		res_load = 1'b0;
		unique case (state_q)
			S_MCLR: begin
				cmd.mem_clr = 1'b1;
				if (sts.mclr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_fire) begin
					cmd.res_clear = 1'b1;
					unique case (in_cmd)
						CMD_WRITE: begin
							cmd.mem_wr_cmd = 1'b1;
							state_d = S_DONE;
						end
						CMD_EXEC: begin
							cmd.mem_rd_pc = 1'b1;
							state_d = S_FHI;
						end
						CMD_READ: begin
							cmd.rd_row = 1'b1;
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_FHI: begin
				cmd.latch_hi   = 1'b1;
				cmd.mem_rd_pc1 = 1'b1;
				state_d = S_FLO;
			end
			S_FLO: begin
				cmd.mem_rd_pc1 = 1'b1;
				state_d = S_GETLO;
			end
			S_GETLO: begin
				cmd.latch_lo = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.is_cls) begin
					cmd.clr_start = 1'b1;
					state_d = S_CLR;
				end else if (sts.is_drw) begin
					cmd.spr_start = 1'b1;
					state_d = sts.spr_none ? S_SEND : S_SRD;
				end else begin
					cmd.exec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_SRD: begin
				cmd.mem_rd_spr = 1'b1;
				state_d = S_SXOR;
			end
			S_SXOR: begin
				cmd.spr_step = 1'b1;
				state_d = sts.spr_last ? S_SEND : S_SRD;
			end
			S_SEND: begin
				cmd.spr_end = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// The result waits here until the output register is free.
				if (!out_busy || out_fire) begin
					res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register; after reset the memory clearing pass runs first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MCLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/c8x_dp.sv]
// ============================================================================
// c8x_dp: CHIP-8 datapath
// Memory, registers, stack, frame buffer and the result fields.
// ============================================================================
module c8x_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  c8x_pkg::c8x_cmd_t           cmd,
	output c8x_pkg::c8x_sts_t           sts,
	input  logic                        cfg_we,
	input  logic [c8x_pkg::MEM_AW-1:0]  cfg_data,
	input  logic                        in_fire,
	input  logic [c8x_pkg::MEM_AW-1:0]  in_address,
	input  logic [7:0]                  in_data,
	input  logic [4:0]                  in_row,
	output logic [c8x_pkg::MEM_AW-1:0]  pc_out,
	output logic [15:0]                 word_out,
	output logic [1:0]                  status_out,
	output logic [7:0]                  flag_out,
	output logic [63:0]                 row_out
);
	import c8x_pkg::*;

	logic [MEM_AW-1:0] pc_q, idx_q;
	logic [7:0]        v_q [16];
	logic [MEM_AW-1:0] stk_q [STACK_DEPTH];
	logic [SP_W-1:0]   sp_q;
	logic [63:0]       fb_q [SCREEN_H];
	logic [15:0]       op_q;
	logic [1:0]        st_q;
	logic [63:0]       rowr_q;
	logic [MEM_AW-1:0] addr_q_in;
	logic [7:0]        data_q_in;
	logic [ROW_AW-1:0] row_q_in;
	logic [ROW_AW-1:0] cnt_q;
	logic [3:0]        scnt_q;
	logic              hit_q;
	logic [7:0]        svx_q, svy_q;
	logic [MEM_AW-1:0] mclr_q;

	// Memory port addressing.
	logic              mem_we;
	logic [MEM_AW-1:0] mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;

	always_comb begin
		mem_we    = cmd.mem_wr_cmd || cmd.mem_clr;
		mem_addr  = pc_q;
		mem_wdata = data_q_in;
		if (cmd.mem_clr) begin
			mem_addr  = mclr_q;
			mem_wdata = '0;
		end else if (cmd.mem_wr_cmd) begin
			mem_addr = addr_q_in;
		end else if (cmd.mem_rd_pc1) begin
			mem_addr = pc_q + MEM_AW'(1);
		end else if (cmd.mem_rd_spr) begin
			mem_addr = idx_q + MEM_AW'(scnt_q);
		end
	end

	c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Command fields taken straight from the input for the write and read commands;
	// both use the live input on the accept cycle.
	assign addr_q_in = in_address;
	assign data_q_in = in_data;
	assign row_q_in  = in_row[ROW_AW-1:0];

	// Opcode fields.
	logic [3:0]  ox, oy, on;
	logic [7:0]  nn, a, b;
	logic [MEM_AW-1:0] nnn, pc2, pc4;
	assign ox  = op_q[11:8];
	assign oy  = op_q[7:4];
	assign on  = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[MEM_AW-1:0];
	assign a   = v_q[ox];
	assign b   = v_q[oy];
	assign pc2 = pc_q + MEM_AW'(2);
	assign pc4 = pc_q + MEM_AW'(4);

	assign sts.mclr_last = (mclr_q == '1);
	assign sts.is_cls    = (op_q == OP_CLS);
	assign sts.is_drw    = (op_q[15:12] == 4'hD);
	assign sts.clr_last  = (cnt_q == ROW_AW'(SCREEN_H - 1));
	assign sts.spr_last  = (scnt_q == on - 4'd1);
	assign sts.spr_none  = (on == 4'd0);

	// Sprite row shifted into screen position with wraparound.
	logic [63:0] spr_mask;
	logic [ROW_AW-1:0] spr_row;
	always_comb begin
		logic [127:0] wide;
		wide = {mem_rdata, 120'd0} >> svx_q[COL_AW-1:0];
		spr_mask = wide[127:64] | wide[63:0];
		spr_row  = svy_q[ROW_AW-1:0] + ROW_AW'(scnt_q);
	end

	// Execute-path results.
	logic [8:0] sum9;
	logic [8:0] dif9, rdif9;
	assign sum9  = {1'b0, a} + {1'b0, b};
	assign dif9  = {1'b0, a} - {1'b0, b};
	assign rdif9 = {1'b0, b} - {1'b0, a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= START_RESET;
			idx_q  <= '0;
			sp_q   <= '0;
			st_q   <= ST_OK;
			op_q   <= '0;
			rowr_q <= '0;
			cnt_q  <= '0;
			scnt_q <= '0;
			hit_q  <= 1'b0;
			svx_q  <= '0;
			svy_q  <= '0;
			mclr_q <= '0;
			for (int i = 0; i < 16; i++) begin
				v_q[i] <= '0;
			end
			for (int i = 0; i < SCREEN_H; i++) begin
				fb_q[i] <= '0;
			end
		end else begin
			if (cmd.mem_clr) begin
				mclr_q <= mclr_q + MEM_AW'(1);
			end
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
			if (cmd.res_clear) begin
				st_q   <= ST_OK;
				op_q   <= '0;
				rowr_q <= '0;
			end
			if (cmd.rd_row) begin
				rowr_q <= fb_q[row_q_in];
			end
			if (cmd.latch_hi) begin
				op_q[15:8] <= mem_rdata;
			end
			if (cmd.latch_lo) begin
				op_q[7:0] <= mem_rdata;
			end
			if (cmd.clr_start) begin
				cnt_q <= '0;
				pc_q  <= pc2;
			end
			if (cmd.clr_step) begin
				fb_q[cnt_q] <= '0;
				cnt_q <= cnt_q + ROW_AW'(1);
			end
			if (cmd.spr_start) begin
				scnt_q <= '0;
				hit_q  <= 1'b0;
				svx_q  <= a;
				svy_q  <= b;
				pc_q   <= pc2;
			end
			if (cmd.spr_step) begin
				fb_q[spr_row] <= fb_q[spr_row] ^ spr_mask;
				if ((fb_q[spr_row] & spr_mask) != '0) begin
					hit_q <= 1'b1;
				end
				scnt_q <= scnt_q + 4'd1;
			end
			if (cmd.spr_end) begin
				v_q[15] <= {7'd0, hit_q};
			end
			if (cmd.exec) begin
				pc_q <= pc2;
				unique case (op_q[15:12])
					4'h0: begin
						if (op_q == OP_RET) begin
							if (sp_q == '0) begin
								st_q <= ST_UNDERFLOW;
								pc_q <= pc_q;
							end else begin
								sp_q <= sp_q - SP_W'(1);
								pc_q <= stk_q[STACK_AW'(sp_q - SP_W'(1))];
							end
						end else begin
							st_q <= ST_IGNORED;
						end
					end
					4'h1: pc_q <= nnn;
					4'h2: begin
						if (sp_q >= SP_W'(STACK_DEPTH)) begin
							st_q <= ST_OVERFLOW;
							pc_q <= pc_q;
						end else begin
							sp_q <= sp_q + SP_W'(1);
							pc_q <= nnn;
						end
					end
					4'h3: if (a == nn) pc_q <= pc4;
					4'h4: if (a != nn) pc_q <= pc4;
					4'h5: if (on == 4'd0 && a == b) pc_q <= pc4;
					4'h6: v_q[ox] <= nn;
					4'h7: v_q[ox] <= a + nn;
					4'h8: begin
						case (on)
							4'h0: v_q[ox] <= b;
							4'h1: v_q[ox] <= a | b;
							4'h2: v_q[ox] <= a & b;
							4'h3: v_q[ox] <= a ^ b;
							4'h4: begin
								v_q[ox] <= sum9[7:0];
								v_q[15] <= {7'd0, sum9[8]};
							end
							4'h5: begin
								v_q[ox] <= dif9[7:0];
								v_q[15] <= {7'd0, !dif9[8]};
							end
							4'h6: begin
								v_q[ox] <= {1'b0, a[7:1]};
								v_q[15] <= {7'd0, a[0]};
							end
							4'h7: begin
								v_q[ox] <= rdif9[7:0];
								v_q[15] <= {7'd0, !rdif9[8]};
							end
							4'hE: begin
								v_q[ox] <= {a[6:0], 1'b0};
								v_q[15] <= {7'd0, a[7]};
							end
							default: st_q <= ST_IGNORED;
						endcase
					end
					4'h9: if (on == 4'd0 && a != b) pc_q <= pc4;
					4'hA: idx_q <= nnn;
					default: st_q <= ST_IGNORED;
				endcase
			end
		end
	end

	// Return stack: no reset, an entry is read only after a call wrote it.
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q[15:12] == 4'h2 && sp_q < SP_W'(STACK_DEPTH)) begin
			stk_q[STACK_AW'(sp_q)] <= pc2;
		end
	end

	assign pc_out     = pc_q;
	assign word_out   = op_q;
	assign status_out = st_q;
	assign flag_out   = v_q[15];
	assign row_out    = rowr_q;

	logic unused_in;
	assign unused_in = in_fire ^ (^in_row);

endmodule
